/* hdl/tar_ustar_header_builder_macros.svh */
// ----------------------------------------------------------------------------
// USTAR header builder: assertion macros
// Property wrappers for the concurrent checks of the top-level module.
// ----------------------------------------------------------------------------
`ifndef TAR_USTAR_HEADER_BUILDER_MACROS_SVH
`define TAR_USTAR_HEADER_BUILDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TUHB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tar ustar header builder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TUHB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tar ustar header builder: next-cycle check failed");

`endif

/* hdl/tuhb_pkg.sv */
// ----------------------------------------------------------------------------
// USTAR header builder package
// Types, field offsets and the byte/word formatting functions of the header.
// ----------------------------------------------------------------------------
package tuhb_pkg;

   localparam int TUHB_NAME_BYTES = 100;

   localparam int REG_W   = 21;
   localparam int VAL_W   = 33;
   localparam int WORD_W  = 64;
   localparam int IDX_W   = 6;
   localparam int CSUM_W  = 18;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 9;

   // octal digits in the widest numeric field
   localparam int OCT_STEPS = 11;

   localparam logic [IDX_W-1:0] LAST_WORD_IDX = IDX_W'(63);

   // header field offsets
   localparam int OFS_MODE  = 100;
   localparam int OFS_UID   = 108;
   localparam int OFS_GID   = 116;
   localparam int OFS_SIZE  = 124;
   localparam int OFS_TIME  = 136;
   localparam int OFS_CSUM  = 148;
   localparam int OFS_TYPE  = 156;
   localparam int OFS_MAGIC = 257;
   localparam int OFS_VER   = 263;

   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [39:0]       MAGIC_STR  = "ustar";

   // constant part of the checksum: digit '0' bias of every octal field,
   // checksum field as spaces, typeflag, magic and version
   localparam int CSUM_CONST = (3 * 7 + 2 * 11) * 48 + 8 * 32 + 48
                               + (117 + 115 + 116 + 97 + 114) + 2 * 48;
   localparam logic [CSUM_W-1:0] CSUM_BASE = CSUM_W'(CSUM_CONST);

   typedef enum logic {
      CMD_APPEND = 1'b0,
      CMD_FINISH = 1'b1
   } tuhb_cmd_type;

   typedef enum logic [1:0] {
      REG_FILE_MODE = 2'd0,
      REG_OWNER_ID  = 2'd1,
      REG_GROUP_ID  = 2'd2
   } tuhb_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_EMIT
   } tuhb_state_type;

   typedef struct packed {
      tuhb_cmd_type       command;
      logic [BYTE_W-1:0]  name_byte;
      logic [VAL_W-1:0]   file_size;
      logic [VAL_W-1:0]   mod_time;
   } tuhb_item_type;

   function automatic logic [BYTE_W-1:0] octal_char(input logic [VAL_W-1:0] v,
                                                     input logic [3:0] idx);
      logic [VAL_W-1:0] sh;
      sh = v >> (3 * idx);
      return CHAR_ZERO + {5'b0, sh[2:0]};
   endfunction

   function automatic logic [BYTE_W-1:0] header_byte(
      input logic [POS_W-1:0]  pos,
      input logic [BYTE_W-1:0] name_b,
      input logic [REG_W-1:0]  mode,
      input logic [REG_W-1:0]  uid,
      input logic [REG_W-1:0]  gid,
      input logic [VAL_W-1:0]  size,
      input logic [VAL_W-1:0]  mtime,
      input logic [CSUM_W-1:0] csum);
      logic [BYTE_W-1:0] b;
      logic [39:0]       msh;
      b   = CHAR_NUL;
      msh = '0;
      if (pos < OFS_MODE) begin
         b = name_b;
      end else if (pos < OFS_MODE + 7) begin
         b = octal_char(VAL_W'(mode), 4'(OFS_MODE + 6 - int'(pos)));
      end else if (pos < OFS_UID) begin
         b = CHAR_NUL;
      end else if (pos < OFS_UID + 7) begin
         b = octal_char(VAL_W'(uid), 4'(OFS_UID + 6 - int'(pos)));
      end else if (pos < OFS_GID) begin
         b = CHAR_NUL;
      end else if (pos < OFS_GID + 7) begin
         b = octal_char(VAL_W'(gid), 4'(OFS_GID + 6 - int'(pos)));
      end else if (pos < OFS_SIZE) begin
         b = CHAR_NUL;
      end else if (pos < OFS_SIZE + 11) begin
         b = octal_char(size, 4'(OFS_SIZE + 10 - int'(pos)));
      end else if (pos < OFS_TIME) begin
         b = CHAR_NUL;
      end else if (pos < OFS_TIME + 11) begin
         b = octal_char(mtime, 4'(OFS_TIME + 10 - int'(pos)));
      end else if (pos < OFS_CSUM) begin
         b = CHAR_NUL;
      end else if (pos < OFS_CSUM + 6) begin
         b = octal_char(VAL_W'(csum), 4'(OFS_CSUM + 5 - int'(pos)));
      end else if (pos == OFS_CSUM + 7) begin
         b = CHAR_SPACE;
      end else if (pos == OFS_TYPE) begin
         b = CHAR_ZERO;
      end else if (pos >= OFS_MAGIC && pos < OFS_MAGIC + 5) begin
         msh = MAGIC_STR >> (8 * (OFS_MAGIC + 4 - int'(pos)));
         b   = msh[BYTE_W-1:0];
      end else if (pos >= OFS_VER && pos < OFS_VER + 2) begin
         b = CHAR_ZERO;
      end
      return b;
   endfunction

   function automatic logic [WORD_W-1:0] build_word(
      input logic [IDX_W-1:0]  k,
      input logic [WORD_W-1:0] name_row,
      input logic [REG_W-1:0]  mode,
      input logic [REG_W-1:0]  uid,
      input logic [REG_W-1:0]  gid,
      input logic [VAL_W-1:0]  size,
      input logic [VAL_W-1:0]  mtime,
      input logic [CSUM_W-1:0] csum);
      logic [WORD_W-1:0] w;
      logic [POS_W-1:0]  pos;
      w = '0;
      for (int i = 0; i < 8; i++) begin
         pos = {k, 3'(i)};
         w[BYTE_W*i +: BYTE_W] = header_byte(pos, name_row[BYTE_W*i +: BYTE_W],
                                             mode, uid, gid, size, mtime, csum);
      end
      return w;
   endfunction

endpackage

/* hdl/tar_ustar_header_builder.sv */
// ----------------------------------------------------------------------------
// USTAR header builder
// Collects an entry name and streams out one 512-byte USTAR tar header.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat per item. command 0 appends name_byte to the name
//            (bytes past the hundredth are dropped and flagged); command 1
//            carries file_size and mod_time and starts a header.
//   rsp_*  : 64 beats per header, word_index 0..63, byte 8k in bits 7:0,
//            last_word on word 63, name_overflow on every word of a header
//            whose name lost bytes.
//   csr_*  : register writes (file mode, owner id, group id), always ready;
//            write them only while no header is in flight.
// Timing: append items are taken one per cycle while the back end is idle.
//   A finish item goes through the checksum unit (one octal digit of every
//   numeric field per cycle), then one word goes out per cycle while
//   rsp_ready is high. The back end takes nothing while a header is built,
//   so the two-entry queue holds two more beats and req_ready then drops
//   until the back end is idle again; a rsp_ready stall holds the word and
//   pauses emission.
// Reset: clears the name count, sum and overflow flag, the queue and the
//   output valid; file_mode returns to octal 0644, owner and group to zero.
// ----------------------------------------------------------------------------
`include "tar_ustar_header_builder_macros.svh"

module tar_ustar_header_builder import tuhb_pkg::*; #(
   parameter int NAME_FIELD_BYTES = TUHB_NAME_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [BYTE_W-1:0]   req_name_byte,
   input  logic [VAL_W-1:0]    req_file_size,
   input  logic [VAL_W-1:0]    req_mod_time,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_header_word,
   output logic [IDX_W-1:0]    rsp_word_index,
   output logic                rsp_last_word,
   output logic                rsp_name_overflow,
   // register write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [REG_W-1:0]    csr_data
);

   logic [REG_W-1:0] file_mode_ff, file_mode_in;
   logic [REG_W-1:0] owner_id_ff, owner_id_in;
   logic [REG_W-1:0] group_id_ff, group_id_in;

   logic          item_valid;
   logic          item_ready;
   tuhb_item_type item;

   // registers take a write on any beat; an unknown index is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      file_mode_in = file_mode_ff;
      owner_id_in  = owner_id_ff;
      group_id_in  = group_id_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FILE_MODE: file_mode_in = csr_data;
            REG_OWNER_ID:  owner_id_in  = csr_data;
            REG_GROUP_ID:  group_id_in  = csr_data;
            default: begin
               file_mode_in = file_mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_mode_ff <= REG_W'(420);
         owner_id_ff  <= '0;
         group_id_ff  <= '0;
      end else begin
         file_mode_ff <= file_mode_in;
         owner_id_ff  <= owner_id_in;
         group_id_ff  <= group_id_in;
      end
   end

   // front end: accept and tag request beats, queue them
   tuhb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_name_byte (req_name_byte),
      .req_file_size (req_file_size),
      .req_mod_time  (req_mod_time),
      .item_valid    (item_valid),
      .item          (item),
      .item_ready    (item_ready)
   );

   // back end: name store, checksum unit and word streamer
   tuhb_back #(
      .NAME_FIELD_BYTES (NAME_FIELD_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_ready        (item_ready),
      .file_mode         (file_mode_ff),
      .owner_id          (owner_id_ff),
      .group_id          (group_id_ff),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_header_word   (rsp_header_word),
      .rsp_word_index    (rsp_word_index),
      .rsp_last_word     (rsp_last_word),
      .rsp_name_overflow (rsp_name_overflow)
   );

   // last_word flags word 63 only
   `TUHB_ASSERT_IMPLY(a_last_is_63, clock, reset, rsp_valid && rsp_last_word, rsp_word_index == LAST_WORD_IDX)
   // a header starts at word zero
   `TUHB_ASSERT_IMPLY(a_first_word, clock, reset, $rose(rsp_valid), rsp_word_index == '0)
   // words of one header follow back to back, in order
   `TUHB_ASSERT_NEXT(a_word_seq, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && (rsp_word_index == IDX_W'($past(rsp_word_index) + 1'b1)))
   // the checksum pass leaves a gap after every header
   `TUHB_ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_ready && rsp_last_word, !rsp_valid)

endmodule

/* hdl/tuhb_front.sv */
// ----------------------------------------------------------------------------
// USTAR header builder: front end
// Accepts request beats, tags the command and queues them for the back end.
// ----------------------------------------------------------------------------
module tuhb_front import tuhb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_command,
   input  logic [BYTE_W-1:0]   req_name_byte,
   input  logic [VAL_W-1:0]    req_file_size,
   input  logic [VAL_W-1:0]    req_mod_time,
   output logic                item_valid,
   output tuhb_item_type       item,
   input  logic                item_ready
);

   localparam int QueueDepth = 2;
   localparam int PtrW       = $clog2(QueueDepth);
   localparam int FillW      = $clog2(QueueDepth + 1);

   tuhb_item_type    queue_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillW-1:0] fill_ff, fill_in;
   logic             push, pop;
   tuhb_item_type    new_item;

   always_comb begin
      new_item.command   = tuhb_cmd_type'(req_command);
      new_item.name_byte = req_name_byte;
      new_item.file_size = req_file_size;
      new_item.mod_time  = req_mod_time;
   end

   assign req_ready  = (fill_ff != FillW'(QueueDepth));
   assign item_valid = (fill_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hdl/tuhb_back.sv */
// ----------------------------------------------------------------------------
// USTAR header builder: back end
// Loads name bytes, sums the checksum digit by digit, streams header words.
// ----------------------------------------------------------------------------
module tuhb_back import tuhb_pkg::*; #(
   parameter int NAME_FIELD_BYTES = TUHB_NAME_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  tuhb_item_type       item,
   output logic                item_ready,
   input  logic [REG_W-1:0]    file_mode,
   input  logic [REG_W-1:0]    owner_id,
   input  logic [REG_W-1:0]    group_id,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [WORD_W-1:0]   rsp_header_word,
   output logic [IDX_W-1:0]    rsp_word_index,
   output logic                rsp_last_word,
   output logic                rsp_name_overflow
);

   localparam int Lanes    = 8;
   localparam int LaneW    = $clog2(Lanes);
   localparam int NameRows = (NAME_FIELD_BYTES + Lanes - 1) / Lanes;
   localparam int RowW     = $clog2(NameRows);
   localparam int CountW   = $clog2(NAME_FIELD_BYTES + 1);
   localparam int SumW     = 15;
   localparam int StepW    = $clog2(OCT_STEPS);

   tuhb_state_type state_ff, state_in;

   logic [Lanes-1:0][BYTE_W-1:0] store_mem [NameRows];
   logic [Lanes-1:0][BYTE_W-1:0] rd_row_ff;
   logic [WORD_W-1:0]            name_row;
   logic                         store_we;
   logic [RowW-1:0]              rd_addr;
   logic                         rd_en;

   logic [CountW-1:0] name_count_ff, name_count_in;
   logic [SumW-1:0]   name_sum_ff, name_sum_in;
   logic              overflow_ff, overflow_in;

   logic [VAL_W-1:0]  size_ff, size_in;
   logic [VAL_W-1:0]  time_ff, time_in;
   logic [REG_W-1:0]  sh_mode_ff, sh_mode_in;
   logic [REG_W-1:0]  sh_uid_ff, sh_uid_in;
   logic [REG_W-1:0]  sh_gid_ff, sh_gid_in;
   logic [VAL_W-1:0]  sh_size_ff, sh_size_in;
   logic [VAL_W-1:0]  sh_time_ff, sh_time_in;
   logic [CSUM_W-1:0] csum_ff, csum_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [5:0]        digit_sum;

   logic [IDX_W-1:0]  widx_ff, widx_in;
   logic              load;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] word_ff;
   logic [IDX_W-1:0]  index_ff;
   logic              last_ff;
   logic              ovf_out_ff;

   assign load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // zero every name position at or past the loaded count
   always_comb begin
      logic [POS_W-1:0] pos;
      name_row = '0;
      for (int i = 0; i < Lanes; i++) begin
         pos = {widx_ff, 3'(i)};
         if (pos < POS_W'(name_count_ff)) begin
            name_row[BYTE_W*i +: BYTE_W] = rd_row_ff[i];
         end
      end
   end

   assign digit_sum = 6'(sh_mode_ff[2:0]) + 6'(sh_uid_ff[2:0]) + 6'(sh_gid_ff[2:0])
                    + 6'(sh_size_ff[2:0]) + 6'(sh_time_ff[2:0]);

   always_comb begin
      state_in      = state_ff;
      item_ready    = 1'b0;
      store_we      = 1'b0;
      name_count_in = name_count_ff;
      name_sum_in   = name_sum_ff;
      overflow_in   = overflow_ff;
      size_in       = size_ff;
      time_in       = time_ff;
      sh_mode_in    = sh_mode_ff;
      sh_uid_in     = sh_uid_ff;
      sh_gid_in     = sh_gid_ff;
      sh_size_in    = sh_size_ff;
      sh_time_in    = sh_time_ff;
      csum_in       = csum_ff;
      step_in       = step_ff;
      widx_in       = widx_ff;
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               if (item.command == CMD_APPEND) begin
                  if (name_count_ff < CountW'(NAME_FIELD_BYTES)) begin
                     store_we      = 1'b1;
                     name_count_in = name_count_ff + 1'b1;
                     name_sum_in   = name_sum_ff + SumW'(item.name_byte);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  size_in    = item.file_size;
                  time_in    = item.mod_time;
                  sh_mode_in = file_mode;
                  sh_uid_in  = owner_id;
                  sh_gid_in  = group_id;
                  sh_size_in = item.file_size;
                  sh_time_in = item.mod_time;
                  csum_in    = CSUM_BASE + CSUM_W'(name_sum_ff);
                  step_in    = '0;
                  state_in   = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            csum_in    = csum_ff + CSUM_W'(digit_sum);
            sh_mode_in = sh_mode_ff >> 3;
            sh_uid_in  = sh_uid_ff >> 3;
            sh_gid_in  = sh_gid_ff >> 3;
            sh_size_in = sh_size_ff >> 3;
            sh_time_in = sh_time_ff >> 3;
            step_in    = step_ff + 1'b1;
            if (step_ff == StepW'(OCT_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load) begin
               widx_in = widx_ff + 1'b1;
               if (widx_ff == LAST_WORD_IDX) begin
                  name_count_in = '0;
                  name_sum_in   = '0;
                  overflow_in   = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // prefetch the name row for the word that goes out next
   assign rd_addr = widx_in[RowW-1:0];
   assign rd_en   = (widx_in < IDX_W'(NameRows));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_count_ff <= '0;
         name_sum_ff   <= '0;
         overflow_ff   <= 1'b0;
         widx_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         name_count_ff <= name_count_in;
         name_sum_ff   <= name_sum_in;
         overflow_ff   <= overflow_in;
         widx_ff       <= widx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff    <= size_in;
      time_ff    <= time_in;
      sh_mode_ff <= sh_mode_in;
      sh_uid_ff  <= sh_uid_in;
      sh_gid_ff  <= sh_gid_in;
      sh_size_ff <= sh_size_in;
      sh_time_ff <= sh_time_in;
      csum_ff    <= csum_in;
      step_ff    <= step_in;
      if (load) begin
         word_ff    <= build_word(widx_ff, name_row, file_mode, owner_id, group_id,
                                  size_ff, time_ff, csum_ff);
         index_ff   <= widx_ff;
         last_ff    <= (widx_ff == LAST_WORD_IDX);
         ovf_out_ff <= overflow_ff;
      end
   end

   // name store: one byte lane written, one row read per cycle
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[name_count_ff[LaneW +: RowW]][name_count_ff[LaneW-1:0]] <= item.name_byte;
      end
      if (rd_en) begin
         rd_row_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_header_word   = word_ff;
   assign rsp_word_index    = index_ff;
   assign rsp_last_word     = last_ff;
   assign rsp_name_overflow = ovf_out_ff;

endmodule

/* test/tar_ustar_header_builder_tb.sv */
// ----------------------------------------------------------------------------
// USTAR header builder testbench
// Drives name bytes, finish items and register writes into the header
// builder, keeps its own image of every 512-byte header that should come out
// and checks each response beat against it, word by word and field by field.
// ----------------------------------------------------------------------------
module tar_ustar_header_builder_tb;
   import tuhb_pkg::*;

   localparam int HEADER_WORDS   = 64;
   localparam int HEADER_BYTES   = 512;
   // cycles with no beat on any channel before the run is declared hung:
   // several times the long receiver hold-off plus a full header drain
   localparam int WATCHDOG_LIMIT = 3000;
   // give the block room to finish a header and go quiet
   localparam int QUIET_CYCLES   = 100;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int REPORT_CAP     = 40;
   localparam int RANDOM_ITEMS   = 8;

   // register index the block does not decode; a write there is dropped
   localparam logic [1:0]       REG_INDEX_SPARE = 2'd3;
   localparam logic [REG_W-1:0] REG_ALL_ONES    = '1;
   localparam logic [VAL_W-1:0] VAL_ALL_ONES    = '1;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [IDX_W-1:0]  index;
      logic              last;
      logic              overflow;
   } header_beat_type;

   // ------------------------------------------------------------------------
   // Clock, reset and the block's ports; every input is known from time zero
   // ------------------------------------------------------------------------
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_command = CMD_APPEND;
   logic [BYTE_W-1:0] req_name_byte = '0;
   logic [VAL_W-1:0]  req_file_size = '0;
   logic [VAL_W-1:0]  req_mod_time = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_header_word;
   logic [IDX_W-1:0]  rsp_word_index;
   logic              rsp_last_word;
   logic              rsp_name_overflow;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [REG_W-1:0]  csr_data = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   tar_ustar_header_builder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_name_byte     (req_name_byte),
      .req_file_size     (req_file_size),
      .req_mod_time      (req_mod_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_header_word   (rsp_header_word),
      .rsp_word_index    (rsp_word_index),
      .rsp_last_word     (rsp_last_word),
      .rsp_name_overflow (rsp_name_overflow),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // ------------------------------------------------------------------------
   // Shadow state of the block: registers, the pending name and the image
   // of the header being predicted
   // ------------------------------------------------------------------------
   logic [REG_W-1:0]  mode_shadow  = REG_W'(420);   // octal 0644 after reset
   logic [REG_W-1:0]  owner_shadow = '0;
   logic [REG_W-1:0]  group_shadow = '0;
   logic [BYTE_W-1:0] pending_name [0:TUHB_NAME_BYTES-1];
   int unsigned       pending_len = 0;
   logic              pending_dropped = 1'b0;
   logic [BYTE_W-1:0] header_image [0:HEADER_BYTES-1];

   header_beat_type   header_beats_due [$];
   header_beat_type   beat_due;

   // stimulus knobs: percentages per cycle, and the hold-off request and countdown
   int unsigned       src_idle_pct = 0;
   int unsigned       sink_stall_pct = 0;
   int unsigned       holdoff_request = 0;
   int unsigned       holdoff_left = 0;

   // tallies for the summary and the verdict
   int unsigned       mismatches = 0;
   int unsigned       items_sent = 0;
   int unsigned       headers_built = 0;
   int unsigned       overflow_headers = 0;
   int unsigned       beats_checked = 0;
   int unsigned       reg_writes = 0;
   int unsigned       req_stall_cycles = 0;
   int unsigned       quiet_count = 0;

   // ------------------------------------------------------------------------
   // Header prediction
   // ------------------------------------------------------------------------

   // right-aligned octal digits at ofs, NUL straight after them
   function automatic void write_octal(input int ofs, input int digits,
                                       input logic [VAL_W-1:0] value);
      logic [VAL_W-1:0] v;
      v = value;
      for (int d = digits - 1; d >= 0; d--) begin
         header_image[ofs + d] = CHAR_ZERO + {5'b0, v[2:0]};
         v = v >> 3;
      end
      header_image[ofs + digits] = CHAR_NUL;
   endfunction

   // Build the whole 512-byte header for one finish beat, queue its 64 words
   // and clear the pending name for the next entry.
   function automatic void build_expected_header(input logic [VAL_W-1:0] fsize,
                                                 input logic [VAL_W-1:0] mtime);
      int unsigned     total;
      header_beat_type beat;
      for (int i = 0; i < HEADER_BYTES; i++) header_image[i] = CHAR_NUL;
      // bytes past the loaded count stay zero, whatever the store still holds
      for (int i = 0; i < pending_len; i++) header_image[i] = pending_name[i];
      write_octal(OFS_MODE, 7, VAL_W'(mode_shadow));
      write_octal(OFS_UID, 7, VAL_W'(owner_shadow));
      write_octal(OFS_GID, 7, VAL_W'(group_shadow));
      write_octal(OFS_SIZE, 11, fsize);
      write_octal(OFS_TIME, 11, mtime);
      // checksum field counts as eight spaces while summing
      for (int i = OFS_CSUM; i < OFS_CSUM + 8; i++) header_image[i] = CHAR_SPACE;
      header_image[OFS_TYPE] = CHAR_ZERO;
      for (int i = 0; i < 5; i++) header_image[OFS_MAGIC + i] = MAGIC_STR[39 - 8*i -: 8];
      header_image[OFS_VER]     = CHAR_ZERO;
      header_image[OFS_VER + 1] = CHAR_ZERO;
      total = 0;
      for (int i = 0; i < HEADER_BYTES; i++) total += header_image[i];
      write_octal(OFS_CSUM, 6, VAL_W'(total & 32'h3FFFF));
      header_image[OFS_CSUM + 7] = CHAR_SPACE;

      for (int k = 0; k < HEADER_WORDS; k++) begin
         for (int i = 0; i < 8; i++) beat.word[8*i +: 8] = header_image[8*k + i];
         beat.index    = IDX_W'(k);
         beat.last     = (k == HEADER_WORDS - 1);
         beat.overflow = pending_dropped;
         header_beats_due.push_back(beat);
      end
      headers_built++;
      if (pending_dropped) overflow_headers++;
      pending_len     = 0;
      pending_dropped = 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Random values
   // ------------------------------------------------------------------------
   function automatic logic [VAL_W-1:0] random_value33();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return '0;
      if (pick < 25) return VAL_ALL_ONES;
      if (pick < 40) return VAL_W'($urandom_range(4095));
      return {1'($urandom_range(1)), 32'($urandom())};
   endfunction

   function automatic logic [REG_W-1:0] random_reg_value();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 20) return '0;
      if (pick < 40) return REG_ALL_ONES;
      return REG_W'($urandom());
   endfunction

   // ------------------------------------------------------------------------
   // Request side: send one beat. Called at a falling edge, returns at the
   // falling edge after acceptance with valid still high, so that a following
   // beat goes out back to back without valid dropping in between.
   // ------------------------------------------------------------------------
   task automatic send_item(input tuhb_cmd_type cmd, input logic [BYTE_W-1:0] nb,
                            input logic [VAL_W-1:0] fsize,
                            input logic [VAL_W-1:0] mtime);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_name_byte <= nb;
      req_file_size <= fsize;
      req_mod_time  <= mtime;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (cmd == CMD_APPEND) begin
         if (pending_len < TUHB_NAME_BYTES) begin
            pending_name[pending_len] = nb;
            pending_len++;
         end else begin
            pending_dropped = 1'b1;
         end
      end else begin
         build_expected_header(fsize, mtime);
      end
      @(negedge clock);
   endtask

   // name bytes with random content; unused size and time fields toggle too
   task automatic send_name(input int len);
      for (int i = 0; i < len; i++)
         send_item(CMD_APPEND, BYTE_W'($urandom()), random_value33(), random_value33());
   endtask

   task automatic send_finish(input logic [VAL_W-1:0] fsize,
                              input logic [VAL_W-1:0] mtime);
      send_item(CMD_FINISH, BYTE_W'($urandom()), fsize, mtime);
   endtask

   // Drop valid, wait for every queued word, then give the block time to
   // finish any name byte still in its input queue.
   task automatic drain_headers();
      req_valid <= 1'b0;
      while (header_beats_due.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   // Register write; only ever issued while the block is idle.
   task automatic write_register(input logic [1:0] idx, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FILE_MODE: mode_shadow  = value;
         REG_OWNER_ID:  owner_shadow = value;
         REG_GROUP_ID:  group_shadow = value;
         default: ;     // undecoded index: the block ignores it
      endcase
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Response side: per-cycle stall, plus a long hold-off when requested.
   // The hold-off is counted here so the request side can keep pushing.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (holdoff_request != 0) begin
         holdoff_left    = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left != 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   function automatic void note_mismatch(input string field, input int idx,
                                         input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("%0t: mismatch in %s of word %0d: expected %h, got %h",
                  $time, field, idx, want, got);
   endfunction

   // Compare every accepted response beat with the oldest queued word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (header_beats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t: unexpected response beat: expected nothing, got word %0d %h",
                        $time, rsp_word_index, rsp_header_word);
         end else begin
            beat_due = header_beats_due.pop_front();
            beats_checked++;
            if (rsp_header_word !== beat_due.word)
               note_mismatch("header_word", beat_due.index, beat_due.word, rsp_header_word);
            if (rsp_word_index !== beat_due.index)
               note_mismatch("word_index", beat_due.index, beat_due.index, rsp_word_index);
            if (rsp_last_word !== beat_due.last)
               note_mismatch("last_word", beat_due.index, beat_due.last, rsp_last_word);
            if (rsp_name_overflow !== beat_due.overflow)
               note_mismatch("name_overflow", beat_due.index, beat_due.overflow,
                             rsp_name_overflow);
         end
      end
   end

   // Watchdog: any beat on any channel resets the count.
   always @(posedge clock) begin
      if (req_valid && !req_ready) req_stall_cycles++;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_count = 0;
      else
         quiet_count++;
      if (quiet_count >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d words still outstanding",
                  $time, header_beats_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Register values straight after reset, field extremes, both byte
   // extremes in the name, empty names and back-to-back finish beats.
   task automatic test_directed_fields();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      @(negedge clock);
      send_finish('0, '0);                          // empty name, zero fields
      send_item(CMD_APPEND, 8'h00, '0, '0);         // zero byte is a real byte
      send_item(CMD_APPEND, 8'hFF, VAL_ALL_ONES, VAL_ALL_ONES);
      send_finish(VAL_ALL_ONES, VAL_ALL_ONES);
      send_item(CMD_APPEND, 8'h55, '0, '0);
      send_item(CMD_APPEND, 8'hAA, '0, '0);
      send_item(CMD_APPEND, 8'h2F, '0, '0);
      send_finish(33'h0AAAAAAAA, 33'h155555555);    // alternating digit bits
      send_finish(33'h155555555, 33'h0AAAAAAAA);
      send_finish(VAL_W'(1), 33'h100000000);        // back to back, empty names
      send_finish(33'h100000000, VAL_W'(1));
      drain_headers();
   endtask

   // Full name field, then a name that spills past it, then a short name so
   // stale bytes from the long one must read back as zero.
   task automatic test_name_field_limit();
      @(negedge clock);
      send_name(TUHB_NAME_BYTES);
      send_finish(random_value33(), random_value33());
      send_name(TUHB_NAME_BYTES + 4);
      send_finish(random_value33(), random_value33());
      send_name(3);
      send_finish(random_value33(), random_value33());
      drain_headers();
   endtask

   // Each register at both extremes, and a write to the undecoded index.
   task automatic test_register_settings();
      write_register(REG_FILE_MODE, '0);
      write_register(REG_OWNER_ID, REG_ALL_ONES);
      write_register(REG_GROUP_ID, '0);
      @(negedge clock);
      send_name(5);
      send_finish(random_value33(), random_value33());
      drain_headers();
      write_register(REG_FILE_MODE, REG_ALL_ONES);
      write_register(REG_OWNER_ID, '0);
      write_register(REG_GROUP_ID, REG_ALL_ONES);
      write_register(REG_INDEX_SPARE, 21'h0F0F0F);
      @(negedge clock);
      send_finish(random_value33(), random_value33());
      drain_headers();
   endtask

   // Whole entries with random content; a share of bare finish beats as noise.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int unsigned first_item;
      int unsigned pick;
      int          len;
      write_register(REG_FILE_MODE, random_reg_value());
      write_register(REG_OWNER_ID, random_reg_value());
      write_register(REG_GROUP_ID, random_reg_value());
      src_idle_pct   = idle_pct;
      sink_stall_pct = stall_pct;
      @(negedge clock);
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 12)      len = 0;
         else if (pick < 82) len = $urandom_range(12, 1);
         else if (pick < 97) len = $urandom_range(60, 13);
         else                len = $urandom_range(TUHB_NAME_BYTES + 4, TUHB_NAME_BYTES - 1);
         send_name(len);
         send_finish(random_value33(), random_value33());
      end
      drain_headers();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
   endtask

   // Hold the response side off for a long stretch while headers keep
   // being requested, so the input queue fills and req_ready drops.
   task automatic test_back_pressure();
      src_idle_pct    = 0;
      sink_stall_pct  = 0;
      @(negedge clock);
      holdoff_request = HOLDOFF_CYCLES;
      for (int e = 0; e < 4; e++) begin
         send_name(3);
         send_finish(random_value33(), random_value33());
      end
      send_finish(random_value33(), random_value33());
      send_finish(random_value33(), random_value33());
      drain_headers();
   endtask

   // ------------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_fields();
      test_name_field_limit();
      test_register_settings();
      test_random_traffic(0, 0);
      test_random_traffic(72, 0);
      test_random_traffic(0, 72);
      test_random_traffic(36, 36);
      test_back_pressure();

      if (header_beats_due.size() != 0) begin
         mismatches++;
         $display("%0t: %0d header words never arrived", $time, header_beats_due.size());
      end
      $display("Covered %0d request beats, %0d headers (%0d with a truncated name), %0d words",
               items_sent, headers_built, overflow_headers, beats_checked);
      $display("checked, %0d register writes; request side stalled %0d cycles, %0d mismatches.",
               reg_writes, req_stall_cycles, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
